// ===== design/sdlp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdlp_pkg: shared types and codes for the switch debouncer
// Switch modes, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package sdlp_pkg;

  // Configuration register file
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_LENGTH = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIME       = 8'd1;

  localparam logic [7:0]  DEBOUNCE_LENGTH_RESET = 8'd5;
  localparam logic [15:0] HOLD_TIME_RESET       = 16'd10;

  // Switch state machine codes
  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_INIT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MONITOR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEB_ON   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_WAIT_OFF = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEB_OFF  = 3'd4;

  // One result per poll tick
  typedef struct packed {
    logic report_valid;
    logic report_pressed;
    logic provision_request;
    logic green_led;
  } result_t;

  // Current configuration, handed to the state machine
  typedef struct packed {
    logic [7:0]  debounce_length;
    logic [15:0] hold_time;
  } cfg_t;

endpackage

// ===== design/sdlp_cfg.sv =====
// ----------------------------------------------------------------------------
// sdlp_cfg: configuration registers
// Holds debounce length and hold time; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module sdlp_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdlp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sdlp_pkg::cfg_t                  cfg
);
  import sdlp_pkg::*;

  // Always able to take a write
  assign cfg_ready = 1'b1;

  // Register decode
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_length <= DEBOUNCE_LENGTH_RESET;
      cfg.hold_time       <= HOLD_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_LENGTH: cfg.debounce_length <= cfg_data[7:0];
        REG_HOLD_TIME:       cfg.hold_time       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/sdlp_fsm.sv =====
// ----------------------------------------------------------------------------
// sdlp_fsm: switch state machine
// Debounce counter, press timestamp and long-hold compare; state moves
// on each step and the result for that tick is given combinationally.
// ----------------------------------------------------------------------------
module sdlp_fsm #(
  parameter int unsigned CLOCK_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            switch_level,
  input  logic [31:0]     clock_now,
  input  sdlp_pkg::cfg_t  cfg,
  output sdlp_pkg::result_t result
);
  import sdlp_pkg::*;

  logic [MODE_W-1:0]      mode, mode_next;
  logic [7:0]             sample_count, sample_count_next;
  logic [CLOCK_WIDTH-1:0] press_time, press_time_next;
  logic                   provision_done, provision_done_next;
  logic                   led_level, led_level_next;

  logic [63:0]            clock_wide;
  logic [63:0]            hold_wide;
  logic [CLOCK_WIDTH-1:0] now;
  logic [CLOCK_WIDTH-1:0] limit;
  logic [7:0]             count_inc;
  logic                   hold_expired;

  // Clock masked to CLOCK_WIDTH, limit wraps at the same width
  assign clock_wide   = {32'd0, clock_now};
  assign hold_wide    = {48'd0, cfg.hold_time};
  assign now          = clock_wide[CLOCK_WIDTH-1:0];
  assign limit        = press_time + hold_wide[CLOCK_WIDTH-1:0];
  assign hold_expired = now > limit;
  assign count_inc    = sample_count + 8'd1;

  // Next state and result for this tick
  always_comb begin
    mode_next           = mode;
    sample_count_next   = sample_count;
    press_time_next     = press_time;
    provision_done_next = provision_done;
    led_level_next      = led_level;
    result.report_valid      = 1'b0;
    result.report_pressed    = 1'b0;
    result.provision_request = 1'b0;

    unique case (mode)
      MODE_INIT: begin
        mode_next         = MODE_MONITOR;
        sample_count_next = 8'd0;
      end
      MODE_MONITOR: begin
        if (!switch_level) begin
          sample_count_next = 8'd0;
          mode_next         = MODE_DEB_ON;
        end
      end
      MODE_DEB_ON: begin
        if (!switch_level) begin
          sample_count_next = count_inc;
          if (count_inc >= cfg.debounce_length) begin
            result.report_valid   = 1'b1;
            result.report_pressed = 1'b1;
            press_time_next       = now;
            provision_done_next   = 1'b0;
            mode_next             = MODE_WAIT_OFF;
          end
        end else begin
          mode_next = MODE_MONITOR;
        end
      end
      MODE_WAIT_OFF: begin
        // long hold: one-shot request, LED on
        if (!provision_done && hold_expired) begin
          provision_done_next      = 1'b1;
          result.provision_request = 1'b1;
          led_level_next           = 1'b1;
        end
        // first high sample: LED off, start release debounce
        if (switch_level) begin
          led_level_next    = 1'b0;
          sample_count_next = 8'd0;
          mode_next         = MODE_DEB_OFF;
        end
      end
      MODE_DEB_OFF: begin
        if (switch_level) begin
          sample_count_next = count_inc;
          if (count_inc >= cfg.debounce_length) begin
            result.report_valid = 1'b1;
            mode_next           = MODE_MONITOR;
          end
        end else begin
          mode_next = MODE_WAIT_OFF;
        end
      end
      default: mode_next = MODE_INIT;
    endcase

    result.green_led = led_level_next;
  end

  // State registers, moved once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_INIT;
      sample_count   <= 8'd0;
      press_time     <= '0;
      provision_done <= 1'b0;
      led_level      <= 1'b0;
    end else if (step) begin
      mode           <= mode_next;
      sample_count   <= sample_count_next;
      press_time     <= press_time_next;
      provision_done <= provision_done_next;
      led_level      <= led_level_next;
    end
  end

endmodule

// ===== design/switch_debounce_long_press.sv =====
// ----------------------------------------------------------------------------
// switch_debounce_long_press: active-low switch debouncer with long press
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   item     | item_valid / item_stall | switch_level, clock_now
//   result   | result_valid / result_stall | report_valid, report_pressed,
//            |                         | provision_request, green_led
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One poll tick per cycle unless a full result register is stalled; a tick goes
// through the input register, then the state machine step into the result register.
// The state update happens when the held tick moves into the result register.
// Reset is synchronous; it clears the mode, counters, LED and both valids.
// result_stall on a full result register holds both stages; item_stall rises
// only while the input register is full and the result register is stalled.
// ----------------------------------------------------------------------------
module switch_debounce_long_press #(
  parameter int unsigned CLOCK_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  // poll tick
  input  logic                             item_valid,
  output logic                             item_stall,
  input  logic                             switch_level,
  input  logic [31:0]                      clock_now,
  // result
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             report_valid,
  output logic                             report_pressed,
  output logic                             provision_request,
  output logic                             green_led,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sdlp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sdlp_pkg::*;

  cfg_t        cfg;
  result_t     fsm_result;
  logic        s1_valid;
  logic        s1_level;
  logic [31:0] s1_clock;
  logic        advance;
  logic        item_accept;

  // Pipeline control
  assign advance     = !result_valid || !result_stall;
  assign item_stall  = s1_valid && !advance;
  assign item_accept = item_valid && !item_stall;

  sdlp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdlp_fsm #(
    .CLOCK_WIDTH (CLOCK_WIDTH)
  ) u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (s1_valid && advance),
    .switch_level (s1_level),
    .clock_now    (s1_clock),
    .cfg          (cfg),
    .result       (fsm_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || advance) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_accept) begin
      s1_level <= switch_level;
      s1_clock <= clock_now;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      report_valid      <= fsm_result.report_valid;
      report_pressed    <= fsm_result.report_pressed;
      provision_request <= fsm_result.provision_request;
      green_led         <= fsm_result.green_led;
    end
  end

`ifndef ASSERT_OFF
  // A press flag never appears without a report
  a_pressed_needs_report: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (report_valid || !report_pressed))
    else $error("report_pressed set without report_valid");

  // Reports and the provision request come from different modes
  a_report_prov_apart: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(report_valid && provision_request))
    else $error("report and provision request in one transaction");

  // Input back-pressure only comes from a stalled, full result register
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (result_valid && result_stall && s1_valid))
    else $error("item_stall without downstream stall");

  // The LED is already off when a release is reported
  a_led_off_on_release: assert property (@(posedge clk) disable iff (rst)
    (result_valid && report_valid && !report_pressed) |-> !green_led)
    else $error("green_led on at release report");
`endif

endmodule

// ===== bench/switch_debounce_long_press_test.sv =====
// ----------------------------------------------------------------------------
// switch_debounce_long_press_test: self-checking bench for the switch debouncer
// Poll ticks are queued per phase, driven through the item channel and
// predicted by a local model of the switch state machine. Every result
// transaction is checked field by field against the oldest prediction.
// Phases change the debounce length, hold time and idling pattern.
// ----------------------------------------------------------------------------
module switch_debounce_long_press_test;

  import sdlp_pkg::*;

  // Register indexes that the block must ignore
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_TOP = 8'hFF;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic        level;
    logic [31:0] now;
  } poll_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic                   switch_level = 1'b1;
  logic [31:0]            clock_now = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic                   report_valid;
  logic                   report_pressed;
  logic                   provision_request;
  logic                   green_led;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  switch_debounce_long_press i_dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .switch_level      (switch_level),
    .clock_now         (clock_now),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .report_valid      (report_valid),
    .report_pressed    (report_pressed),
    .provision_request (provision_request),
    .green_led         (green_led),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bench bookkeeping
  poll_t       tick_queue[$];
  result_t     predicted[$];
  poll_t       next_tick;
  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_queued = 0;
  logic [31:0] gen_clock = '0;

  // Local copy of the switch machine and its configuration
  logic [7:0]        deb_len = DEBOUNCE_LENGTH_RESET;
  logic [15:0]       hold_len = HOLD_TIME_RESET;
  logic [MODE_W-1:0] sw_mode = MODE_INIT;
  logic [7:0]        hit_count = '0;
  logic [31:0]       press_stamp = '0;
  logic              prov_fired = 1'b0;
  logic              led_on = 1'b0;

  // Advance the switch machine by one poll tick and return its result
  function automatic result_t debounce_step(input logic pin_high, input logic [31:0] now);
    result_t     res;
    logic [31:0] deadline;
    res = '0;
    case (sw_mode)
      MODE_INIT: begin
        sw_mode = MODE_MONITOR;
        hit_count = '0;
      end
      MODE_MONITOR: begin
        if (!pin_high) begin
          hit_count = '0;
          sw_mode = MODE_DEB_ON;
        end
      end
      MODE_DEB_ON: begin
        if (!pin_high) begin
          hit_count = hit_count + 8'd1;
          if (hit_count >= deb_len) begin
            res.report_valid = 1'b1;
            res.report_pressed = 1'b1;
            press_stamp = now;
            prov_fired = 1'b0;
            sw_mode = MODE_WAIT_OFF;
          end
        end else begin
          sw_mode = MODE_MONITOR;
        end
      end
      MODE_WAIT_OFF: begin
        // long hold: one request once the clock passes the wrapped deadline
        if (!prov_fired) begin
          deadline = press_stamp + {16'd0, hold_len};
          if (now > deadline) begin
            prov_fired = 1'b1;
            res.provision_request = 1'b1;
            led_on = 1'b1;
          end
        end
        if (pin_high) begin
          led_on = 1'b0;
          hit_count = '0;
          sw_mode = MODE_DEB_OFF;
        end
      end
      MODE_DEB_OFF: begin
        if (pin_high) begin
          hit_count = hit_count + 8'd1;
          if (hit_count >= deb_len) begin
            res.report_valid = 1'b1;
            sw_mode = MODE_MONITOR;
          end
        end else begin
          sw_mode = MODE_WAIT_OFF;
        end
      end
      default: begin
        sw_mode = MODE_INIT;
      end
    endcase
    res.green_led = led_on;
    return res;
  endfunction

  function automatic bit sender_idles();
    int unsigned pct;
    pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit receiver_stalls();
    int unsigned pct;
    pct = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  // Item driver: predicts each accepted tick and presents the next one
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      switch_level <= 1'b1;
      clock_now <= '0;
      sw_mode = MODE_INIT;
      hit_count = '0;
      press_stamp = '0;
      prov_fired = 1'b0;
      led_on = 1'b0;
    end else begin
      if (item_valid && !item_stall)
        predicted.push_back(debounce_step(switch_level, clock_now));
      if (!item_valid || !item_stall) begin
        if (tick_queue.size() != 0 && !sender_idles()) begin
          next_tick = tick_queue.pop_front();
          item_valid <= 1'b1;
          switch_level <= next_tick.level;
          clock_now <= next_tick.now;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      fault_count++;
    end
  endfunction

  // Result monitor
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (predicted.size() == 0) begin
          $display("%0t: result transaction with none expected, actual %b", $time,
                   {report_valid, report_pressed, provision_request, green_led});
          fault_count++;
        end else begin
          want = predicted.pop_front();
          check_field("report_valid", want.report_valid, report_valid);
          check_field("report_pressed", want.report_pressed, report_pressed);
          check_field("provision_request", want.provision_request, provision_request);
          check_field("green_led", want.green_led, green_led);
        end
      end
      result_stall <= receiver_stalls();
    end
  end

  // Watchdog: ends the run when no channel moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("switch_debounce_long_press_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write; the local model follows the block's masking
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEBOUNCE_LENGTH: deb_len = data[7:0];
      REG_HOLD_TIME:       hold_len = data;
      default:             ;
    endcase
  endtask

  // Wait until every queued tick has been accepted and answered
  task automatic drain();
    while (tick_queue.size() != 0 || item_valid || predicted.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_tick_at(input logic level, input logic [31:0] now);
    tick_queue.push_back('{level: level, now: now});
    ticks_queued++;
  endtask

  // Clock mostly creeps forward, sometimes jumps, wraps or goes anywhere
  task automatic add_tick(input logic level);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80)
      gen_clock = gen_clock + $urandom_range(1, 4);
    else if (pick < 92)
      gen_clock = gen_clock + $urandom_range(0, 70000);
    else if (pick < 96)
      gen_clock = $urandom;
    else
      gen_clock = 32'hFFFF_FFFF - $urandom_range(0, 40);
    add_tick_at(level, gen_clock);
  endtask

  task automatic add_run(input logic level, input int unsigned count);
    repeat (count) add_tick(level);
  endtask

  // One press and release, with optional bounces on either edge
  task automatic add_press_cycle();
    int unsigned span;
    span = (deb_len == 0) ? 1 : deb_len;
    add_run(1'b1, $urandom_range(1, 3));
    if ($urandom_range(0, 3) == 0) begin
      add_run(1'b0, $urandom_range(1, span));
      add_tick(1'b1);
    end
    add_run(1'b0, deb_len + 1 + $urandom_range(0, 40));
    if ($urandom_range(0, 3) == 0) begin
      add_run(1'b1, $urandom_range(1, span));
      add_tick(1'b0);
    end
    add_run(1'b1, deb_len + 1 + $urandom_range(0, 3));
  endtask

  task automatic fill(input int unsigned count);
    int unsigned stop_at;
    stop_at = ticks_queued + count;
    while (ticks_queued < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        add_press_cycle();
      end else begin
        repeat ($urandom_range(1, 8)) add_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, no idling
    idle_mode = IDLE_NONE;
    fill(100);
    drain();

    // directed ticks with a debounce length of one and no hold time
    write_reg(REG_DEBOUNCE_LENGTH, 16'd1);
    write_reg(REG_HOLD_TIME, 16'd0);
    add_tick_at(1'b1, 32'd0);
    add_tick_at(1'b1, 32'd1);
    add_tick_at(1'b0, 32'd2);
    add_tick_at(1'b1, 32'd3);            // bounce back to monitor
    add_tick_at(1'b0, 32'd4);
    add_tick_at(1'b0, 32'd5);            // press reported
    add_tick_at(1'b0, 32'd5);            // equal to deadline, no request
    add_tick_at(1'b0, 32'd6);            // request, LED on
    add_tick_at(1'b1, 32'd7);            // LED off
    add_tick_at(1'b0, 32'd8);            // bounce back to wait-till-off
    add_tick_at(1'b1, 32'd9);
    add_tick_at(1'b1, 32'd10);           // release reported
    add_tick_at(1'b0, 32'hFFFF_FFFE);
    add_tick_at(1'b0, 32'hFFFF_FFFF);    // press at the top of the clock
    add_tick_at(1'b0, 32'd0);            // clock wrapped below deadline
    add_tick_at(1'b1, 32'd1);
    add_tick_at(1'b1, 32'd2);
    add_tick_at(1'b0, 32'd100);
    add_tick_at(1'b0, 32'd101);
    add_tick_at(1'b1, 32'd102);          // request and release on one tick
    add_tick_at(1'b1, 32'd103);
    drain();

    // zero debounce length via masked data, sender idling
    write_reg(REG_DEBOUNCE_LENGTH, 16'hA500);
    write_reg(REG_HOLD_TIME, 16'd3);
    idle_mode = IDLE_SENDER;
    fill(180);
    drain();

    // longest hold time, receiver stalling
    write_reg(REG_DEBOUNCE_LENGTH, 16'd2);
    write_reg(REG_HOLD_TIME, 16'hFFFF);
    idle_mode = IDLE_RECEIVER;
    fill(180);
    drain();

    // longest debounce, both sides idling
    write_reg(REG_DEBOUNCE_LENGTH, 16'h00FF);
    write_reg(REG_HOLD_TIME, 16'd20);
    idle_mode = IDLE_BOTH;
    fill(1);
    drain();

    // writes to unused indexes must leave the registers alone
    write_reg(REG_DEBOUNCE_LENGTH, 16'd3);
    write_reg(REG_HOLD_TIME, 16'd50);
    write_reg(REG_SPARE_LOW, 16'h0001);
    write_reg(REG_SPARE_TOP, 16'hFFFF);
    idle_mode = IDLE_BOTH;
    fill(60);
    drain();
    idle_mode = IDLE_NONE;
    fill(60);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("switch_debounce_long_press_test: done, clean");
    end else begin
      $display("switch_debounce_long_press_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== switch_debounce_long_press.f =====
design/sdlp_pkg.sv
design/sdlp_cfg.sv
design/sdlp_fsm.sv
design/switch_debounce_long_press.sv
bench/switch_debounce_long_press_test.sv
